/* rtl/core/cbp_pkg.sv */
package cbp_pkg;

    // Width of the configuration register index on the write channel.
    localparam int CFG_INDEX_BITS = 8;

    // Largest slice of a wide operand that goes through one multiplier.
    localparam int CHUNK_BITS = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_X = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_Y = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CTRL1_X = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CTRL1_Y = 8'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CTRL2_X = 8'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CTRL2_Y = 8'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_END_X   = 8'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_END_Y   = 8'd7;

    // Load enables of the three register stages of one interpolation unit.
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_c;
    } lerp_en_t;

endpackage

/* rtl/core/cbp_lerp.sv */
// Exact linear interpolation mix = lo * 2^TF + t * (hi - lo), which equals
// lo * (1 - t) + hi * t with t scaled by 2^TF. Three register stages:
// difference, chunked partial products, and the final sum.
module cbp_lerp #(
    parameter int W  = 16,
    parameter int TF = 16
) (
    input  logic                   aclk,
    input  cbp_pkg::lerp_en_t      en,
    input  logic [TF:0]            t,
    input  logic signed [W-1:0]    lo,
    input  logic signed [W-1:0]    hi,
    output logic signed [W+TF-1:0] mix
);

    localparam int DW   = W + 1;
    localparam int TW   = TF + 1;
    localparam int CH   = cbp_pkg::CHUNK_BITS;
    localparam int NCH  = (DW + CH - 1) / CH;
    localparam int TOPW = DW - (NCH - 1) * CH;
    localparam int PW   = CH + TW + 2;
    localparam int SW   = DW + TW + 1;
    localparam int OW   = W + TF;

    logic signed [DW-1:0] diff_reg;
    logic signed [W-1:0]  lo_a_reg;
    logic [TF:0]          t_a_reg;
    logic signed [PW-1:0] pp_next [NCH];
    logic signed [PW-1:0] pp_reg [NCH];
    logic signed [W-1:0]  lo_b_reg;
    logic signed [SW-1:0] sum_next;
    logic signed [OW-1:0] mix_reg;

    always_ff @(posedge aclk) begin
        if (en.load_a) begin
            diff_reg <= DW'(hi) - DW'(lo);
            lo_a_reg <= lo;
            t_a_reg  <= t;
        end
    end

    // The difference is cut into slices; all but the top one are unsigned.
    for (genvar c = 0; c < NCH; c++) begin : g_chunk
        logic signed [CH:0] slice;
        if (c < NCH - 1) begin : g_low
            assign slice = $signed({1'b0, diff_reg[c*CH +: CH]});
        end else begin : g_top
            assign slice = (CH + 1)'($signed(diff_reg[DW-1 -: TOPW]));
        end
        assign pp_next[c] = slice * $signed({1'b0, t_a_reg});
    end

    always_ff @(posedge aclk) begin
        if (en.load_b) begin
            for (int c = 0; c < NCH; c++) begin
                pp_reg[c] <= pp_next[c];
            end
            lo_b_reg <= lo_a_reg;
        end
    end

    always_comb begin
        sum_next = SW'(lo_b_reg) <<< TF;
        for (int c = 0; c < NCH; c++) begin
            sum_next = sum_next + (SW'(pp_reg[c]) <<< (c * CH));
        end
    end

    always_ff @(posedge aclk) begin
        if (en.load_c) begin
            mix_reg <= sum_next[OW-1:0];
        end
    end

    assign mix = mix_reg;

endmodule

/* rtl/core/cubic_bezier_point.sv */
// Cubic Bezier point evaluator. Each input transfer carries a parameter t in
// signed fixed point with T_FRAC_BITS fraction bits; t is clamped to 0..1 and
// one point (point_x, point_y) comes out per input, in order. The curve is
// evaluated exactly by three levels of de Casteljau interpolation, so the
// result equals the Bernstein-weighted sum of the four points divided by
// 2^(3*T_FRAC_BITS), truncated toward zero. The block accepts one t per clock
// while the pipeline has room. There are 11 register stages: one clamp stage,
// three interpolation levels of three stages each (difference, partial
// products, sum), and one rounding stage. A result is valid once it reaches
// the rounding stage. A stall on the output backs up through per-stage valid
// bits; empty stages keep filling. The eight point
// registers are written through the cfg channel (always ready), and must only
// be changed while no item is in flight.
module cubic_bezier_point #(
    parameter int  COORD_BITS  = 16,
    parameter int  T_FRAC_BITS = 16,
    localparam int S_TDATA_W   = ((T_FRAC_BITS + 2 + 7) / 8) * 8,
    localparam int M_TDATA_W   = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [S_TDATA_W-1:0]               s_tdata,   // param_t
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [M_TDATA_W-1:0]               m_tdata,   // point_x, point_y
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cbp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]              cfg_data
);

    localparam int NS  = 11;
    localparam int TF  = T_FRAC_BITS;
    localparam int W1  = COORD_BITS + TF;
    localparam int W2  = COORD_BITS + 2 * TF;
    localparam int W3  = COORD_BITS + 3 * TF;
    localparam logic [TF:0] T_ONE = (TF + 1)'(1) << TF;

    logic signed [COORD_BITS-1:0] pts_reg [2][4];
    logic [NS-1:0]                valid_reg;
    logic [NS-1:0]                en;
    logic [TF:0]                  t_pipe_reg [7];
    logic [TF+1:0]                param_t;
    logic [TF:0]                  t_next;
    cbp_pkg::lerp_en_t            en_l [3];
    logic signed [W1-1:0]         b_w [2][3];
    logic signed [W2-1:0]         c_w [2][2];
    logic signed [W3-1:0]         d_w [2];
    logic signed [COORD_BITS-1:0] point_next [2];
    logic signed [COORD_BITS-1:0] point_x_reg;
    logic signed [COORD_BITS-1:0] point_y_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 2; a++) begin
                for (int p = 0; p < 4; p++) begin
                    pts_reg[a][p] <= '0;
                end
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                cbp_pkg::REG_START_X: pts_reg[0][0] <= cfg_data;
                cbp_pkg::REG_START_Y: pts_reg[1][0] <= cfg_data;
                cbp_pkg::REG_CTRL1_X: pts_reg[0][1] <= cfg_data;
                cbp_pkg::REG_CTRL1_Y: pts_reg[1][1] <= cfg_data;
                cbp_pkg::REG_CTRL2_X: pts_reg[0][2] <= cfg_data;
                cbp_pkg::REG_CTRL2_Y: pts_reg[1][2] <= cfg_data;
                cbp_pkg::REG_END_X:   pts_reg[0][3] <= cfg_data;
                cbp_pkg::REG_END_Y:   pts_reg[1][3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its content moves on this cycle.
    always_comb begin
        en[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign s_tready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Clamp t to 0..1; negative values have the top bit set.
    assign param_t = s_tdata[TF+1:0];

    always_comb begin
        if (param_t[TF+1]) begin
            t_next = '0;
        end else if (param_t[TF] && (|param_t[TF-1:0])) begin
            t_next = T_ONE;
        end else begin
            t_next = param_t[TF:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            t_pipe_reg[0] <= t_next;
        end
        for (int i = 1; i < 7; i++) begin
            if (en[i]) begin
                t_pipe_reg[i] <= t_pipe_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_en
        assign en_l[k] = '{load_a: en[1+3*k], load_b: en[2+3*k], load_c: en[3+3*k]};
    end

    for (genvar ax = 0; ax < 2; ax++) begin : g_axis
        for (genvar i = 0; i < 3; i++) begin : g_l1
            cbp_lerp #(.W(COORD_BITS), .TF(TF)) u_lerp (
                .aclk (aclk),
                .en   (en_l[0]),
                .t    (t_pipe_reg[0]),
                .lo   (pts_reg[ax][i]),
                .hi   (pts_reg[ax][i+1]),
                .mix  (b_w[ax][i])
            );
        end
        for (genvar i = 0; i < 2; i++) begin : g_l2
            cbp_lerp #(.W(W1), .TF(TF)) u_lerp (
                .aclk (aclk),
                .en   (en_l[1]),
                .t    (t_pipe_reg[3]),
                .lo   (b_w[ax][i]),
                .hi   (b_w[ax][i+1]),
                .mix  (c_w[ax][i])
            );
        end
        cbp_lerp #(.W(W2), .TF(TF)) u_l3 (
            .aclk (aclk),
            .en   (en_l[2]),
            .t    (t_pipe_reg[6]),
            .lo   (c_w[ax][0]),
            .hi   (c_w[ax][1]),
            .mix  (d_w[ax])
        );

        // Drop the 3*TF fraction bits, rounding negative values toward zero.
        assign point_next[ax] = d_w[ax][3*TF +: COORD_BITS]
            + COORD_BITS'(d_w[ax][W3-1] && (|d_w[ax][3*TF-1:0]));
    end

    always_ff @(posedge aclk) begin
        if (en[NS-1]) begin
            point_x_reg <= point_next[0];
            point_y_reg <= point_next[1];
        end
    end

    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = M_TDATA_W'({point_y_reg, point_x_reg});

`ifndef SYNTHESIS
    a_ready_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (!(&valid_reg) || m_tready) |-> s_tready)
        else $error("input stalled while the pipeline has room");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted transfer did not enter the first stage");

    a_t_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[0] |-> (t_pipe_reg[0] <= T_ONE))
        else $error("clamped t exceeds one");

    a_item_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> ($countones(valid_reg) == $past($countones(valid_reg))
            + int'($past(s_tvalid && s_tready)) - int'($past(m_tvalid && m_tready))))
        else $error("items lost or duplicated in the pipeline");
`endif

endmodule
